// File: sv/ucfp_pkg.sv
package ucfp_pkg;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HDR2,
    PH_FUNC,
    PH_BODY
  } parse_phase_e;

  typedef enum logic {
    BK_IDLE,
    BK_ACK
  } back_state_e;

  localparam logic [7:0] HDR_FIRST      = 8'h55;
  localparam logic [7:0] HDR_SECOND     = 8'hAA;
  localparam logic [7:0] FN_BACKLIGHT   = 8'h01;
  localparam logic [7:0] FN_LEVEL       = 8'h02;
  localparam logic [7:0] FN_BEEPER      = 8'h03;
  localparam logic [7:0] FN_TIME_SYNC   = 8'h04;
  localparam logic [3:0] FRAME_LEN_SYNC = 4'd11;
  localparam logic [3:0] FRAME_LEN_STD  = 4'd8;
  localparam logic [3:0] FIRST_BODY_IDX = 4'd3;
  localparam int unsigned PAYLOAD_LEN   = 7;
  localparam logic [2:0] ACK_LAST_BEAT  = 3'd7;
  localparam logic [7:0] RES_OK         = 8'h01;
  localparam logic [7:0] RES_FAIL       = 8'h00;
  localparam logic       KIND_ACK       = 1'b0;
  localparam logic       KIND_SYNC      = 1'b1;

  localparam logic       CFG_LEVEL_MIN  = 1'b0;
  localparam logic       CFG_LEVEL_MAX  = 1'b1;
  localparam logic [7:0] LEVEL_MIN_RST  = 8'd1;
  localparam logic [7:0] LEVEL_MAX_RST  = 8'd5;

  typedef struct packed {
    logic [7:0]                       func;
    logic [PAYLOAD_LEN-1:0][7:0]      payload;
  } cmd_t;

  function automatic logic [7:0] ack_byte(input logic [2:0] beat,
                                          input logic [7:0] func,
                                          input logic [7:0] result);
    logic [7:0] b;
    case (beat)
      3'd0:    b = HDR_SECOND;
      3'd1:    b = HDR_FIRST;
      3'd2:    b = func;
      3'd3:    b = result;
      3'd7:    b = HDR_SECOND ^ HDR_FIRST ^ func ^ result;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: sv/ucfp_ifs.sv
interface ucfp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ucfp_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [7:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

interface ucfp_res_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  tx_byte;
  logic        last;
  logic        backlight_on;
  logic [7:0]  light_level;
  logic        beeper_on;
  logic [15:0] year;
  logic [7:0]  month;
  logic [7:0]  day;
  logic [7:0]  hour;
  logic [7:0]  minute;
  logic [7:0]  second;
  modport source (output valid, output kind, output tx_byte, output last,
                  output backlight_on, output light_level, output beeper_on,
                  output year, output month, output day, output hour,
                  output minute, output second, input ready);
  modport sink   (input valid, input kind, input tx_byte, input last,
                  input backlight_on, input light_level, input beeper_on,
                  input year, input month, input day, input hour,
                  input minute, input second, output ready);
endinterface

// File: sv/ucfp_front.sv
module ucfp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  ucfp_rx_if.sink           rx_i,
  input  logic              q_full_i,
  output logic              push_o,
  output ucfp_pkg::cmd_t    cmd_o
);

  ucfp_pkg::parse_phase_e phase_q, phase_d;
  logic [7:0] func_q, func_d;
  logic [3:0] idx_q, idx_d;
  logic [7:0] xor_q, xor_d;
  logic [ucfp_pkg::PAYLOAD_LEN-1:0][7:0] pay_q;

  logic       accept;
  logic [7:0] b;
  logic [3:0] flen;
  logic       frame_end;
  logic       store;
  logic [3:0] slot_full;
  logic [2:0] slot;

  assign rx_i.ready = !q_full_i;
  assign accept     = rx_i.valid && !q_full_i;
  assign b          = rx_i.rx_byte;
  assign flen       = (func_q == ucfp_pkg::FN_TIME_SYNC) ? ucfp_pkg::FRAME_LEN_SYNC
                                                         : ucfp_pkg::FRAME_LEN_STD;
  assign frame_end  = (phase_q == ucfp_pkg::PH_BODY) && !(idx_q < (flen - 4'd1));
  assign slot_full  = idx_q - ucfp_pkg::FIRST_BODY_IDX;
  assign slot       = slot_full[2:0];

  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      unique case (phase_q)
        ucfp_pkg::PH_HUNT: begin
          phase_d = (b == ucfp_pkg::HDR_FIRST) ? ucfp_pkg::PH_HDR2 : ucfp_pkg::PH_HUNT;
        end
        ucfp_pkg::PH_HDR2: begin
          if (b == ucfp_pkg::HDR_SECOND) begin
            phase_d = ucfp_pkg::PH_FUNC;
          end else if (b == ucfp_pkg::HDR_FIRST) begin
            phase_d = ucfp_pkg::PH_HDR2;
          end else begin
            phase_d = ucfp_pkg::PH_HUNT;
          end
        end
        ucfp_pkg::PH_FUNC: begin
          phase_d = ucfp_pkg::PH_BODY;
        end
        ucfp_pkg::PH_BODY: begin
          phase_d = frame_end ? ucfp_pkg::PH_HUNT : ucfp_pkg::PH_BODY;
        end
        default: phase_d = ucfp_pkg::PH_HUNT;
      endcase
    end
  end

  always_comb begin
    func_d = func_q;
    idx_d  = idx_q;
    xor_d  = xor_q;
    store  = 1'b0;
    push_o = 1'b0;
    if (accept) begin
      unique case (phase_q)
        ucfp_pkg::PH_FUNC: begin
          func_d = b;
          xor_d  = ucfp_pkg::HDR_FIRST ^ ucfp_pkg::HDR_SECOND ^ b;
          idx_d  = ucfp_pkg::FIRST_BODY_IDX;
        end
        ucfp_pkg::PH_BODY: begin
          if (frame_end) begin
            idx_d  = 4'd0;
            push_o = (xor_q == b);
          end else begin
            store = 1'b1;
            xor_d = xor_q ^ b;
            idx_d = idx_q + 4'd1;
          end
        end
        default: ;
      endcase
    end
  end

  assign cmd_o.func    = func_q;
  assign cmd_o.payload = pay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ucfp_pkg::PH_HUNT;
      func_q  <= 8'h00;
      idx_q   <= 4'd0;
      xor_q   <= 8'h00;
    end else begin
      phase_q <= phase_d;
      func_q  <= func_d;
      idx_q   <= idx_d;
      xor_q   <= xor_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store) begin
      pay_q[slot] <= b;
    end
  end

endmodule

// File: sv/ucfp_cmd_fifo.sv
module ucfp_cmd_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ucfp_pkg::cmd_t cmd_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output ucfp_pkg::cmd_t cmd_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  ucfp_pkg::cmd_t  mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

// File: sv/ucfp_back.sv
module ucfp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  ucfp_pkg::cmd_t cmd_i,
  output logic           pop_o,
  ucfp_cfg_if.sink       cfg_i,
  ucfp_res_if.source     res_o
);

  ucfp_pkg::back_state_e state_q, state_d;
  logic [2:0] beat_q, beat_d;
  logic [7:0] func_q, func_d;
  logic [7:0] result_q, result_d;

  logic [7:0] lvl_min_q, lvl_max_q;
  logic       bl_q, bl_d;
  logic [7:0] lvl_q, lvl_d;
  logic       beep_q, beep_d;

  logic        out_valid_q, out_valid_d;
  logic        kind_q, kind_d;
  logic [7:0]  tx_q, tx_d;
  logic        last_q, last_d;
  logic        obl_q;
  logic [7:0]  olvl_q;
  logic        obeep_q;
  logic [15:0] year_q, year_d;
  logic [7:0]  month_q, month_d, day_q, day_d, hour_q, hour_d;
  logic [7:0]  minute_q, minute_d, second_q, second_d;

  logic       load;
  logic [7:0] d;
  logic [7:0] exec_res;
  logic       is_sync;

  assign load  = !out_valid_q || res_o.ready;
  assign d     = cmd_i.payload[0];
  assign pop_o = (state_q == ucfp_pkg::BK_IDLE) && cmd_valid_i && load;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    bl_d     = bl_q;
    lvl_d    = lvl_q;
    beep_d   = beep_q;
    exec_res = ucfp_pkg::RES_FAIL;
    is_sync  = 1'b0;
    if (pop_o) begin
      unique case (cmd_i.func)
        ucfp_pkg::FN_BACKLIGHT: begin
          bl_d     = (d != 8'h00);
          exec_res = ucfp_pkg::RES_OK;
        end
        ucfp_pkg::FN_LEVEL: begin
          if ((d >= lvl_min_q) && (d <= lvl_max_q)) begin
            lvl_d    = d;
            exec_res = ucfp_pkg::RES_OK;
          end
        end
        ucfp_pkg::FN_BEEPER: begin
          beep_d   = (d != 8'h00);
          exec_res = ucfp_pkg::RES_OK;
        end
        ucfp_pkg::FN_TIME_SYNC: begin
          is_sync = 1'b1;
        end
        default: exec_res = ucfp_pkg::RES_FAIL;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ucfp_pkg::BK_IDLE: begin
        if (pop_o && !is_sync) begin
          state_d = ucfp_pkg::BK_ACK;
        end
      end
      ucfp_pkg::BK_ACK: begin
        if (load && (beat_q == ucfp_pkg::ACK_LAST_BEAT)) begin
          state_d = ucfp_pkg::BK_IDLE;
        end
      end
      default: state_d = ucfp_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    beat_d      = beat_q;
    func_d      = func_q;
    result_d    = result_q;
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    tx_d        = tx_q;
    last_d      = last_q;
    year_d      = year_q;
    month_d     = month_q;
    day_d       = day_q;
    hour_d      = hour_q;
    minute_d    = minute_q;
    second_d    = second_q;
    if (load) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ucfp_pkg::BK_IDLE: begin
        if (pop_o) begin
          out_valid_d = 1'b1;
          year_d      = 16'h0000;
          month_d     = 8'h00;
          day_d       = 8'h00;
          hour_d      = 8'h00;
          minute_d    = 8'h00;
          second_d    = 8'h00;
          if (is_sync) begin
            kind_d   = ucfp_pkg::KIND_SYNC;
            tx_d     = 8'h00;
            last_d   = 1'b1;
            year_d   = {cmd_i.payload[0], cmd_i.payload[1]};
            month_d  = cmd_i.payload[2];
            day_d    = cmd_i.payload[3];
            hour_d   = cmd_i.payload[4];
            minute_d = cmd_i.payload[5];
            second_d = cmd_i.payload[6];
          end else begin
            kind_d   = ucfp_pkg::KIND_ACK;
            tx_d     = ucfp_pkg::ack_byte(3'd0, cmd_i.func, exec_res);
            last_d   = 1'b0;
            func_d   = cmd_i.func;
            result_d = exec_res;
            beat_d   = 3'd1;
          end
        end
      end
      ucfp_pkg::BK_ACK: begin
        if (load) begin
          out_valid_d = 1'b1;
          kind_d      = ucfp_pkg::KIND_ACK;
          tx_d        = ucfp_pkg::ack_byte(beat_q, func_q, result_q);
          last_d      = (beat_q == ucfp_pkg::ACK_LAST_BEAT);
          beat_d      = beat_q + 3'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ucfp_pkg::BK_IDLE;
      beat_q      <= 3'd0;
      out_valid_q <= 1'b0;
      bl_q        <= 1'b0;
      lvl_q       <= 8'h00;
      beep_q      <= 1'b0;
      lvl_min_q   <= ucfp_pkg::LEVEL_MIN_RST;
      lvl_max_q   <= ucfp_pkg::LEVEL_MAX_RST;
    end else begin
      state_q     <= state_d;
      beat_q      <= beat_d;
      out_valid_q <= out_valid_d;
      bl_q        <= bl_d;
      lvl_q       <= lvl_d;
      beep_q      <= beep_d;
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          ucfp_pkg::CFG_LEVEL_MIN: lvl_min_q <= cfg_i.data;
          ucfp_pkg::CFG_LEVEL_MAX: lvl_max_q <= cfg_i.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    func_q   <= func_d;
    result_q <= result_d;
    kind_q   <= kind_d;
    tx_q     <= tx_d;
    last_q   <= last_d;
    year_q   <= year_d;
    month_q  <= month_d;
    day_q    <= day_d;
    hour_q   <= hour_d;
    minute_q <= minute_d;
    second_q <= second_d;
    if (load) begin
      obl_q   <= bl_d;
      olvl_q  <= lvl_d;
      obeep_q <= beep_d;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.kind         = kind_q;
  assign res_o.tx_byte      = tx_q;
  assign res_o.last         = last_q;
  assign res_o.backlight_on = obl_q;
  assign res_o.light_level  = olvl_q;
  assign res_o.beeper_on    = obeep_q;
  assign res_o.year         = year_q;
  assign res_o.month        = month_q;
  assign res_o.day          = day_q;
  assign res_o.hour         = hour_q;
  assign res_o.minute       = minute_q;
  assign res_o.second       = second_q;

endmodule

// File: sv/uart_command_frame_parser_top.sv
// channel  | dir | fields                                   | accepted when
// rx_i     | in  | rx_byte                                  | valid && ready
// cfg_i    | in  | index (0 level min, 1 level max), data   | valid && ready
// res_o    | out | kind, tx_byte, last, status, date/time   | valid && ready
//
// Takes one received byte per cycle while the command queue has room.
// A good frame yields 8 ack results, or one time sync result;
// the back end runs one command at a time, so ack bursts set the sustained rate.
// Reset clears the parser, queue, settings and output valid; config is 1 and 5.
// The output register stalls the back end only; the queue decouples the parser.
module uart_command_frame_parser_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ucfp_rx_if.sink     rx_i,
  ucfp_cfg_if.sink    cfg_i,
  ucfp_res_if.source  res_o
);

  logic           push;
  logic           q_full;
  logic           q_valid;
  logic           pop;
  ucfp_pkg::cmd_t front_cmd;
  ucfp_pkg::cmd_t back_cmd;

  ucfp_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rx_i     (rx_i),
    .q_full_i (q_full),
    .push_o   (push),
    .cmd_o    (front_cmd)
  );

  ucfp_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .cmd_o   (back_cmd)
  );

  ucfp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (back_cmd),
    .pop_o       (pop),
    .cfg_i       (cfg_i),
    .res_o       (res_o)
  );

endmodule

// File: test/ucfp_response_checker.sv
`timescale 1ns / 100ps

module ucfp_response_checker (
  input  logic clk_i,
  input  logic rst_ni,
  ucfp_rx_if   rx,
  ucfp_cfg_if  cfg,
  ucfp_res_if  res,
  output int   fail_count,
  output int   pending,
  output int   checked
);

  typedef struct {
    logic        kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic        bl_on;
    logic [7:0]  bl_level;
    logic        bp_on;
    logic [15:0] year;
    logic [7:0]  month;
    logic [7:0]  day;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  second;
  } reply_t;

  reply_t       pending_replies [$];

  ucfp_pkg::parse_phase_e phase;
  logic [7:0]   func;
  logic [3:0]   body_idx;
  logic [7:0]   frame_xor;
  logic [7:0]   payload [ucfp_pkg::PAYLOAD_LEN];
  logic         bl_en;
  logic [7:0]   lvl;
  logic         bp_en;
  logic [7:0]   lvl_min;
  logic [7:0]   lvl_max;

  task automatic report(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      report($sformatf("result %0d %s expected %0h got %0h", checked, name, want, got));
    end
  endtask

  function automatic reply_t status_reply();
    reply_t r;
    r = '{default: '0};
    r.bl_on    = bl_en;
    r.bl_level = lvl;
    r.bp_on    = bp_en;
    return r;
  endfunction

  task automatic queue_ack(input logic [7:0] fn, input logic [7:0] result);
    logic [7:0] frame [8];
    reply_t     r;
    frame = '{ucfp_pkg::HDR_SECOND, ucfp_pkg::HDR_FIRST, fn, result, 8'h00, 8'h00, 8'h00,
              ucfp_pkg::HDR_SECOND ^ ucfp_pkg::HDR_FIRST ^ fn ^ result};
    for (int k = 0; k < 8; k++) begin
      r = status_reply();
      r.kind    = ucfp_pkg::KIND_ACK;
      r.tx_byte = frame[k];
      r.last    = (k == 7);
      pending_replies.push_back(r);
    end
  endtask

  task automatic run_command();
    logic [7:0] d;
    reply_t     r;
    d = payload[0];
    case (func)
      ucfp_pkg::FN_BACKLIGHT: begin
        bl_en = (d != 8'h00);
        queue_ack(func, ucfp_pkg::RES_OK);
      end
      ucfp_pkg::FN_LEVEL: begin
        if (d >= lvl_min && d <= lvl_max) begin
          lvl = d;
          queue_ack(func, ucfp_pkg::RES_OK);
        end else begin
          queue_ack(func, ucfp_pkg::RES_FAIL);
        end
      end
      ucfp_pkg::FN_BEEPER: begin
        bp_en = (d != 8'h00);
        queue_ack(func, ucfp_pkg::RES_OK);
      end
      ucfp_pkg::FN_TIME_SYNC: begin
        r = status_reply();
        r.kind   = ucfp_pkg::KIND_SYNC;
        r.last   = 1'b1;
        r.year   = {payload[0], payload[1]};
        r.month  = payload[2];
        r.day    = payload[3];
        r.hour   = payload[4];
        r.minute = payload[5];
        r.second = payload[6];
        pending_replies.push_back(r);
      end
      default: begin
        queue_ack(func, ucfp_pkg::RES_FAIL);
      end
    endcase
  endtask

  task automatic parse_rx_byte(input logic [7:0] b);
    logic [3:0] flen;
    logic [2:0] slot;
    case (phase)
      ucfp_pkg::PH_HDR2: begin
        if (b == ucfp_pkg::HDR_SECOND) phase = ucfp_pkg::PH_FUNC;
        else phase = (b == ucfp_pkg::HDR_FIRST) ? ucfp_pkg::PH_HDR2 : ucfp_pkg::PH_HUNT;
      end
      ucfp_pkg::PH_FUNC: begin
        func      = b;
        frame_xor = ucfp_pkg::HDR_FIRST ^ ucfp_pkg::HDR_SECOND ^ b;
        body_idx  = ucfp_pkg::FIRST_BODY_IDX;
        phase     = ucfp_pkg::PH_BODY;
      end
      ucfp_pkg::PH_BODY: begin
        flen = (func == ucfp_pkg::FN_TIME_SYNC) ? ucfp_pkg::FRAME_LEN_SYNC
                                                : ucfp_pkg::FRAME_LEN_STD;
        if (body_idx < flen - 4'd1) begin
          slot = 3'(body_idx - ucfp_pkg::FIRST_BODY_IDX);
          if (slot < ucfp_pkg::PAYLOAD_LEN) payload[slot] = b;
          frame_xor = frame_xor ^ b;
          body_idx  = body_idx + 4'd1;
        end else begin
          phase    = ucfp_pkg::PH_HUNT;
          body_idx = 4'd0;
          if (frame_xor == b) run_command();
        end
      end
      default: begin
        phase = (b == ucfp_pkg::HDR_FIRST) ? ucfp_pkg::PH_HDR2 : ucfp_pkg::PH_HUNT;
      end
    endcase
  endtask

  task automatic check_reply();
    reply_t e;
    if (pending_replies.size() == 0) begin
      report($sformatf("result with nothing expected, kind %0d tx_byte %0h",
                       res.kind, res.tx_byte));
    end else begin
      e = pending_replies.pop_front();
      compare_field("kind", 16'(e.kind), 16'(res.kind));
      compare_field("tx_byte", 16'(e.tx_byte), 16'(res.tx_byte));
      compare_field("last", 16'(e.last), 16'(res.last));
      compare_field("backlight_on", 16'(e.bl_on), 16'(res.backlight_on));
      compare_field("light_level", 16'(e.bl_level), 16'(res.light_level));
      compare_field("beeper_on", 16'(e.bp_on), 16'(res.beeper_on));
      compare_field("year", e.year, res.year);
      compare_field("month", 16'(e.month), 16'(res.month));
      compare_field("day", 16'(e.day), 16'(res.day));
      compare_field("hour", 16'(e.hour), 16'(res.hour));
      compare_field("minute", 16'(e.minute), 16'(res.minute));
      compare_field("second", 16'(e.second), 16'(res.second));
      checked++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_replies.delete();
      phase      = ucfp_pkg::PH_HUNT;
      func       = 8'h00;
      body_idx   = 4'd0;
      frame_xor  = 8'h00;
      bl_en      = 1'b0;
      lvl        = 8'h00;
      bp_en      = 1'b0;
      lvl_min    = ucfp_pkg::LEVEL_MIN_RST;
      lvl_max    = ucfp_pkg::LEVEL_MAX_RST;
      fail_count = 0;
      checked    = 0;
    end else begin
      if (res.valid && res.ready) check_reply();
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == ucfp_pkg::CFG_LEVEL_MIN) lvl_min = cfg.data;
        else lvl_max = cfg.data;
      end
      if (rx.valid && rx.ready) parse_rx_byte(rx.rx_byte);
    end
    pending = pending_replies.size();
  end

endmodule

// File: test/uart_command_frame_parser_top_test.sv
`timescale 1ns / 100ps

module uart_command_frame_parser_top_test;

  localparam int LIMIT        = 200000;
  localparam int IDLE_GAP     = 24;
  localparam int HOLD_CYCLES  = 400;
  localparam int NUM_PHASES   = 6;
  localparam int PHASE_BYTES  = 16;
  localparam int HOLD_BYTES   = 48;
  localparam int HOLD_PHASE   = 2;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ucfp_rx_if  rx ();
  ucfp_cfg_if cfg ();
  ucfp_res_if res ();

  int fail_count;
  int pending;
  int checked;

  int         cycle_count = 0;
  int         bytes_sent  = 0;
  int         frames_sent = 0;
  int         bad_frames  = 0;
  int         cfg_writes  = 0;
  bit         tx_quiet    = 1'b0;
  bit         hold_req    = 1'b0;
  logic [7:0] cur_min;
  logic [7:0] cur_max;

  uart_command_frame_parser_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  ucfp_response_checker checker_i (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx         (rx),
    .cfg        (cfg),
    .res        (res),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", LIMIT, pending);
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int draw_gap(input bit quiet);
    return quiet ? 0 : $urandom_range(0, 7);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (bytes_sent % 16 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
    gap = draw_gap(tx_quiet);
    bytes_sent++;
    if (gap > 0) begin
      rx.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    rx.rx_byte <= b;
    rx.valid   <= 1'b1;
    do @(posedge clk_i); while (!(rx.valid && rx.ready));
    @(negedge clk_i);
  endtask

  task automatic send_frame(input logic [7:0] fn, input logic [7:0] first,
                            input int fill, input bit corrupt);
    logic [7:0] body [$];
    logic [7:0] sum;
    logic [7:0] flip;
    int         len;
    len  = int'((fn == ucfp_pkg::FN_TIME_SYNC) ? ucfp_pkg::FRAME_LEN_SYNC
                                               : ucfp_pkg::FRAME_LEN_STD);
    body = {ucfp_pkg::HDR_FIRST, ucfp_pkg::HDR_SECOND, fn, first};
    while (body.size() < len - 1) begin
      body.push_back((fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill));
    end
    sum = 8'h00;
    foreach (body[k]) sum = sum ^ body[k];
    if (corrupt) begin
      flip = 8'($urandom_range(1, 255));
      sum  = sum ^ flip;
      bad_frames++;
    end
    body.push_back(sum);
    foreach (body[k]) send_byte(body[k]);
    frames_sent++;
  endtask

  function automatic logic [7:0] choose_func();
    case ($urandom_range(0, 9))
      0, 1:    return ucfp_pkg::FN_BACKLIGHT;
      2, 3:    return ucfp_pkg::FN_LEVEL;
      4, 5:    return ucfp_pkg::FN_BEEPER;
      6, 7:    return ucfp_pkg::FN_TIME_SYNC;
      8:       return 8'($urandom_range(0, 255));
      default: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] choose_data(input logic [7:0] fn);
    logic [7:0] d;
    d = 8'($urandom_range(0, 255));
    if (fn == ucfp_pkg::FN_LEVEL) begin
      case ($urandom_range(0, 4))
        1:       d = cur_min;
        2:       d = cur_max;
        3:       d = cur_max + 8'd1;
        4:       d = cur_min - 8'd1;
        default: d = d;
      endcase
    end else if (fn == ucfp_pkg::FN_BACKLIGHT || fn == ucfp_pkg::FN_BEEPER) begin
      if ($urandom_range(0, 1) == 0) d = 8'h00;
    end
    return d;
  endfunction

  task automatic settle();
    rx.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (IDLE_GAP) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    cfg.index <= idx;
    cfg.data  <= val;
    cfg.valid <= 1'b1;
    do @(posedge clk_i); while (!(cfg.valid && cfg.ready));
    @(negedge clk_i);
    cfg_writes++;
  endtask

  task automatic apply_levels(input logic [7:0] lo, input logic [7:0] hi);
    write_reg(ucfp_pkg::CFG_LEVEL_MIN, lo);
    write_reg(ucfp_pkg::CFG_LEVEL_MAX, hi);
    cfg.valid <= 1'b0;
    cur_min = lo;
    cur_max = hi;
  endtask

  initial begin
    int         w;
    int         n;
    bit         quiet;
    res.ready = 1'b0;
    n     = 0;
    quiet = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (n % 16 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (hold_req) begin
        w        = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        w = draw_gap(quiet);
      end
      if (w > 0) begin
        res.ready <= 1'b0;
        repeat (w) @(negedge clk_i);
      end
      res.ready <= 1'b1;
      do @(posedge clk_i); while (!(res.valid && res.ready));
      n++;
      @(negedge clk_i);
    end
  end

  initial begin
    int         budget;
    int         directed_end;
    logic [7:0] fn;
    logic [7:0] b;
    rx.valid   = 1'b0;
    rx.rx_byte = 8'h00;
    cfg.valid  = 1'b0;
    cfg.index  = ucfp_pkg::CFG_LEVEL_MIN;
    cfg.data   = 8'h00;
    cur_min    = ucfp_pkg::LEVEL_MIN_RST;
    cur_max    = ucfp_pkg::LEVEL_MAX_RST;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_byte(ucfp_pkg::HDR_FIRST);
    send_frame(ucfp_pkg::FN_BACKLIGHT, 8'hFF, 0, 1'b0);
    send_frame(ucfp_pkg::FN_TIME_SYNC, 8'hFF, 8'hFF, 1'b0);
    send_frame(ucfp_pkg::FN_LEVEL, 8'h00, 0, 1'b1);
    directed_end = bytes_sent;
    budget       = directed_end;

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase > 0) begin
        settle();
        case (phase)
          1:       apply_levels(8'h00, 8'hFF);
          2:       apply_levels(8'hFF, 8'h00);
          3:       apply_levels(8'h07, 8'h07);
          4:       apply_levels(8'hFF, 8'hFF);
          default: apply_levels(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        endcase
      end
      if (phase == HOLD_PHASE) hold_req = 1'b1;
      budget += (phase == HOLD_PHASE) ? HOLD_BYTES : PHASE_BYTES;
      while (bytes_sent < budget) begin
        case ($urandom_range(0, 19))
          14, 15: begin
            fn = choose_func();
            send_frame(fn, choose_data(fn), -1, 1'b1);
          end
          16: begin
            repeat ($urandom_range(1, 4)) begin
              b = 8'($urandom_range(0, 255));
              if (b == ucfp_pkg::HDR_FIRST) b = 8'h00;
              send_byte(b);
            end
          end
          17: begin
            send_byte(ucfp_pkg::HDR_FIRST);
            b = 8'($urandom_range(0, 255));
            if (b == ucfp_pkg::HDR_SECOND) b = 8'h00;
            send_byte(b);
          end
          18: begin
            send_byte(ucfp_pkg::HDR_FIRST);
            send_byte(ucfp_pkg::HDR_SECOND);
            send_byte(choose_func());
            repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)));
          end
          19: begin
            fn = choose_func();
            send_frame(fn, $urandom_range(0, 1) ? 8'hFF : 8'h00, -1, 1'b0);
          end
          default: begin
            fn = choose_func();
            send_frame(fn, choose_data(fn), -1, 1'b0);
          end
        endcase
      end
    end

    settle();
    $display("covered %0d rx bytes in %0d frames (%0d with bad checksum), %0d register writes",
             bytes_sent, frames_sent, bad_frames, cfg_writes);
    $display("checked %0d results across %0d level settings", checked, NUM_PHASES);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/ucfp_pkg.sv
sv/ucfp_ifs.sv
sv/ucfp_front.sv
sv/ucfp_cmd_fifo.sv
sv/ucfp_back.sv
sv/uart_command_frame_parser_top.sv
test/ucfp_response_checker.sv
test/uart_command_frame_parser_top_test.sv
